@@ rtl/cbvb_pkg.sv @@
package cbvb_pkg;

    typedef logic signed [31:0] t_coord;
    typedef logic signed [19:0] t_tval;
    typedef logic [2:0]         t_cfg_idx;

    localparam t_cfg_idx CFG_FIRST_Z = 3'd0;
    localparam t_cfg_idx CFG_LAST_Z  = 3'd1;
    localparam t_cfg_idx CFG_P2_X    = 3'd2;
    localparam t_cfg_idx CFG_P2_Y    = 3'd3;
    localparam t_cfg_idx CFG_P3_X    = 3'd4;
    localparam t_cfg_idx CFG_P3_Y    = 3'd5;

    localparam int DIV_QB  = 20;
    localparam int DIV_LAT = DIV_QB + 3;
    localparam int PIPE_LAT = DIV_LAT + 6;

    localparam t_tval T_MAX = 20'sh7FFFF;
    localparam t_tval T_MIN = 20'sh80000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   deg;
    } t_side;

endpackage

@@ rtl/cubic_bezier_vertex_bend_unit.sv @@
// Throughput: one vertex per cycle while not stalled (o_stall low).
// t comes from a restoring divider with 20 iteration stages.
// A two-entry output register/skid pair absorbs downstream stall.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads
// first_z = 0, last_z = 1.0, control points zero.
module cubic_bezier_vertex_bend_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cbvb_pkg::t_coord     i_x_in,
    input  cbvb_pkg::t_coord     i_y_in,
    input  cbvb_pkg::t_coord     i_z_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cbvb_pkg::t_coord     o_x_out,
    output cbvb_pkg::t_coord     o_y_out,
    output cbvb_pkg::t_coord     o_z_out,
    output logic                 o_degenerate,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  cbvb_pkg::t_cfg_idx   i_cfg_index,
    input  cbvb_pkg::t_coord     i_cfg_data
);
    import cbvb_pkg::*;

    localparam int SA = DIV_LAT;
    localparam int LAST = PIPE_LAT - 1;

    t_coord r_first_z, r_last_z, r_p2_x, r_p2_y, r_p3_x, r_p3_y;

    logic  en;
    logic  r_v  [0:LAST];
    t_side r_sd [0:LAST];
    t_side n_sd;

    logic signed [32:0] w_den;
    logic signed [32:0] w_dz;
    logic signed [48:0] w_num;
    t_tval              w_t;

    logic signed [20:0] n_u;
    logic signed [20:0] r_u;
    t_tval              r_t;
    logic signed [39:0] r_ut;
    logic signed [60:0] r_a, r_b;
    logic signed [63:0] n_w2f, n_w3f;
    logic signed [28:0] r_w2, r_w3;
    logic signed [60:0] r_m2x, r_m3x, r_m2y, r_m3y;
    logic signed [61:0] n_sx, n_sy;
    logic signed [45:0] r_dx, r_dy;
    logic signed [46:0] n_ox, n_oy;

    t_side r_out, r_skid;
    logic  r_ov, r_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_z <= '0;
            r_last_z  <= 32'sd65536;
            r_p2_x    <= '0;
            r_p2_y    <= '0;
            r_p3_x    <= '0;
            r_p3_y    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_Z: r_first_z <= i_cfg_data;
                CFG_LAST_Z:  r_last_z  <= i_cfg_data;
                CFG_P2_X:    r_p2_x    <= i_cfg_data;
                CFG_P2_Y:    r_p2_y    <= i_cfg_data;
                CFG_P3_X:    r_p3_x    <= i_cfg_data;
                CFG_P3_Y:    r_p3_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en      = !r_full;
    assign o_stall = r_full;

    always_comb begin
        w_den = 33'(r_last_z) - 33'(r_first_z);
        w_dz  = 33'(i_z_in) - 33'(r_first_z);
        w_num = {w_dz, 16'd0};
        n_sd.x = i_x_in;
        n_sd.y = i_y_in;
        n_sd.z = i_z_in;
        n_sd.deg = (r_last_z == r_first_z);
    end

    cbvb_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (w_num),
        .i_den (w_den),
        .o_t   (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= LAST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_comb begin
        n_u   = 21'sd65536 - 21'(w_t);
        n_w2f = (64'(r_a) <<< 1) + 64'(r_a) + 64'sh8000_0000;
        n_w3f = (64'(r_b) <<< 1) + 64'(r_b) + 64'sh8000_0000;
        n_sx  = 62'(r_m2x) + 62'(r_m3x) + 62'sd32768;
        n_sy  = 62'(r_m2y) + 62'(r_m3y) + 62'sd32768;
        n_ox  = 47'(r_sd[LAST-1].x) + 47'(r_dx);
        n_oy  = 47'(r_sd[LAST-1].y) + 47'(r_dy);
    end

    function automatic t_coord sat32(input logic signed [46:0] v);
        if (v[46:31] == '0 || v[46:31] == '1) return v[31:0];
        return v[46] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= n_sd;
            for (int k = 1; k < LAST; k++) r_sd[k] <= r_sd[k-1];
            r_sd[LAST].z   <= r_sd[LAST-1].z;
            r_sd[LAST].deg <= r_sd[LAST-1].deg;
            r_sd[LAST].x   <= r_sd[LAST-1].deg ? r_sd[LAST-1].x : sat32(n_ox);
            r_sd[LAST].y   <= r_sd[LAST-1].deg ? r_sd[LAST-1].y : sat32(n_oy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t   <= w_t;
            r_u   <= n_u;
            r_ut  <= n_u * w_t;
            r_a   <= r_ut * r_u;
            r_b   <= r_ut * r_t;
            r_w2  <= n_w2f[60:32];
            r_w3  <= n_w3f[60:32];
            r_m2x <= r_w2 * r_p2_x;
            r_m3x <= r_w3 * r_p3_x;
            r_m2y <= r_w2 * r_p2_y;
            r_m3y <= r_w3 * r_p3_y;
            r_dx  <= n_sx[61:16];
            r_dy  <= n_sy[61:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_full <= 1'b0;
        end else if (r_full) begin
            if (!i_stall) begin
                r_out  <= r_skid;
                r_full <= 1'b0;
            end
        end else if (r_v[LAST]) begin
            if (!r_ov || !i_stall) begin
                r_out <= r_sd[LAST];
                r_ov  <= 1'b1;
            end else begin
                r_skid <= r_sd[LAST];
                r_full <= 1'b1;
            end
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid      = r_ov;
    assign o_x_out      = r_out.x;
    assign o_y_out      = r_out.y;
    assign o_z_out      = r_out.z;
    assign o_degenerate = r_out.deg;

`ifndef ASSERT_OFF
    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_ov) else $error("skid beat without output beat");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && i_stall |=> r_full && $stable(r_skid)) else $error("skid lost");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full && !i_stall |=> !r_full && r_ov) else $error("skid not drained");
`endif

endmodule

@@ rtl/cbvb_div.sv @@
module cbvb_div (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [48:0]     i_num,
    input  logic signed [32:0]     i_den,
    output cbvb_pkg::t_tval        o_t
);
    import cbvb_pkg::*;

    logic [47:0] r_an;
    logic [31:0] r_ad0;
    logic        r_neg0;
    logic [48:0] n_an;
    logic [32:0] n_ad;

    logic [31:0]       r_rem [0:DIV_QB];
    logic [DIV_QB-1:0] r_lo  [0:DIV_QB];
    logic [DIV_QB-1:0] r_q   [0:DIV_QB];
    logic [31:0]       r_ad  [0:DIV_QB];
    logic              r_neg [0:DIV_QB];
    logic              r_ovf [0:DIV_QB];
    t_tval             r_t;

    always_comb begin
        n_an = i_num[48] ? -i_num : i_num;
        n_ad = i_den[32] ? -i_den : i_den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_an   <= n_an[47:0];
            r_ad0  <= n_ad[31:0];
            r_neg0 <= i_num[48] ^ i_den[32];
            // a quotient of 2^DIV_QB or more is flagged as overflow and saturates
            r_rem[0] <= 32'(r_an[47:DIV_QB]);
            r_lo[0]  <= r_an[DIV_QB-1:0];
            r_q[0]   <= '0;
            r_ad[0]  <= r_ad0;
            r_neg[0] <= r_neg0;
            r_ovf[0] <= 32'(r_an[47:DIV_QB]) >= r_ad0;
        end
    end

    for (genvar k = 1; k <= DIV_QB; k++) begin : g_iter
        logic [32:0] w_trial;
        logic        w_ge;
        always_comb begin
            w_trial = {r_rem[k-1], r_lo[k-1][DIV_QB-1]};
            w_ge    = w_trial >= {1'b0, r_ad[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? 32'(w_trial - {1'b0, r_ad[k-1]}) : w_trial[31:0];
                r_lo[k]  <= {r_lo[k-1][DIV_QB-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][DIV_QB-2:0], w_ge};
                r_ad[k]  <= r_ad[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[DIV_QB]) begin
                r_t <= (r_ovf[DIV_QB] || r_q[DIV_QB][DIV_QB-1]) ? T_MAX
                                                                : t_tval'(r_q[DIV_QB]);
            end else begin
                r_t <= (r_ovf[DIV_QB] || (r_q[DIV_QB][DIV_QB-1]
                        && (|r_q[DIV_QB][DIV_QB-2:0]))) ? T_MIN
                                                        : t_tval'(-r_q[DIV_QB]);
            end
        end
    end

    assign o_t = r_t;

endmodule

@@ dv/cbvb_checker.sv @@
`timescale 1ns / 1ps

module cbvb_checker
    import cbvb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_stall_up,
    input  t_coord   i_x_in,
    input  t_coord   i_y_in,
    input  t_coord   i_z_in,
    input  logic     i_out_valid,
    input  logic     i_stall_dn,
    input  t_coord   i_x_out,
    input  t_coord   i_y_out,
    input  t_coord   i_z_out,
    input  logic     i_degenerate,
    input  logic     i_cfg_valid,
    input  logic     i_cfg_ready,
    input  t_cfg_idx i_cfg_index,
    input  t_coord   i_cfg_data,
    output int       o_errors,
    output int       o_pending,
    output int       o_results,
    output int       o_degen_seen,
    output int       o_sat_seen
);

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   deg;
    } bent_vertex_t;

    bent_vertex_t bent_q[$];
    longint first_z, last_z, p2x, p2y, p3x, p3y;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shr(longint v, int s);
        return floor_shr(v + (longint'(1) <<< (s - 1)), s);
    endfunction

    function automatic t_coord clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_coord'(v);
    endfunction

    function automatic bent_vertex_t bend_vertex(t_coord x, t_coord y, t_coord z);
        bent_vertex_t r;
        longint den, t, u, w2, w3, dx, dy;
        r.z = z;
        den = last_z - first_z;
        if (den == 0) begin
            r.x = x;
            r.y = y;
            r.deg = 1'b1;
            return r;
        end
        t = ((longint'(z) - first_z) * 65536) / den;
        if (t > 524287) t = 524287;
        if (t < -524288) t = -524288;
        u = 65536 - t;
        w2 = round_shr(3 * u * u * t, 32);
        w3 = round_shr(3 * u * t * t, 32);
        dx = round_shr(w2 * p2x + w3 * p3x, 16);
        dy = round_shr(w2 * p2y + w3 * p3y, 16);
        r.x = clamp32(longint'(x) + dx);
        r.y = clamp32(longint'(y) + dy);
        r.deg = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        bent_vertex_t e;
        int n_err;
        n_err = 0;
        if (!i_rst_n) begin
            first_z <= 0;
            last_z  <= 65536;
            p2x <= 0; p2y <= 0; p3x <= 0; p3y <= 0;
            bent_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIRST_Z: first_z <= longint'(i_cfg_data);
                    CFG_LAST_Z:  last_z  <= longint'(i_cfg_data);
                    CFG_P2_X:    p2x     <= longint'(i_cfg_data);
                    CFG_P2_Y:    p2y     <= longint'(i_cfg_data);
                    CFG_P3_X:    p3x     <= longint'(i_cfg_data);
                    CFG_P3_Y:    p3y     <= longint'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_up) begin
                e = bend_vertex(i_x_in, i_y_in, i_z_in);
                bent_q.push_back(e);
                if (e.deg) o_degen_seen <= o_degen_seen + 1;
                if (!e.deg && (e.x == 32'sh7FFFFFFF || e.x == 32'sh80000000))
                    o_sat_seen <= o_sat_seen + 1;
            end
            if (i_out_valid && !i_stall_dn) begin
                o_results <= o_results + 1;
                if (bent_q.size() == 0) begin
                    $error("unexpected output beat");
                    n_err++;
                end else begin
                    e = bent_q.pop_front();
                    if (i_x_out !== e.x) begin
                        $error("x_out exp %0d got %0d", e.x, i_x_out);
                        n_err++;
                    end
                    if (i_y_out !== e.y) begin
                        $error("y_out exp %0d got %0d", e.y, i_y_out);
                        n_err++;
                    end
                    if (i_z_out !== e.z) begin
                        $error("z_out exp %0d got %0d", e.z, i_z_out);
                        n_err++;
                    end
                    if (i_degenerate !== e.deg) begin
                        $error("degenerate exp %0d got %0d", e.deg, i_degenerate);
                        n_err++;
                    end
                end
                o_errors <= o_errors + n_err;
            end
        end
    end

    initial begin
        o_errors = 0;
        o_results = 0;
        o_degen_seen = 0;
        o_sat_seen = 0;
    end

    assign o_pending = bent_q.size();

endmodule

@@ dv/tb_cubic_bezier_vertex_bend_unit.sv @@
`timescale 1ns / 1ps

module tb_cubic_bezier_vertex_bend_unit;
    import cbvb_pkg::*;

    localparam int WATCHDOG = 20000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    t_coord   x_in = '0, y_in = '0, z_in = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_coord   x_out, y_out, z_out;
    logic     degenerate;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    t_cfg_idx cfg_index = CFG_FIRST_Z;
    t_coord   cfg_data = '0;
    int       errors, pending, results, degen_seen, sat_seen;
    int       idle_cycles = 0;
    int       sent = 0;
    int       stall_mode = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    cubic_bezier_vertex_bend_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_x_in(x_in), .i_y_in(y_in), .i_z_in(z_in),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_x_out(x_out), .o_y_out(y_out), .o_z_out(z_out),
        .o_degenerate(degenerate),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    cbvb_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_up(in_stall),
        .i_x_in(x_in), .i_y_in(y_in), .i_z_in(z_in),
        .i_out_valid(out_valid), .i_stall_dn(out_stall),
        .i_x_out(x_out), .i_y_out(y_out), .i_z_out(z_out),
        .i_degenerate(degenerate),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_degen_seen(degen_seen), .o_sat_seen(sat_seen)
    );

    // receiver stall pattern: none, light random, heavy random, moderate random
    always @(posedge clk) begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) == 0);
            2: out_stall <= ($urandom_range(0, 2) != 0);
            default: out_stall <= ($urandom_range(0, 15) < 5);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired, pending %0d", pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_coord val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending != 0) @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
    endtask

    task automatic send_vertex(t_coord x, t_coord y, t_coord z);
        in_valid <= 1'b1;
        x_in <= x;
        y_in <= y;
        z_in <= z;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic pause_sender;
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            2: return ($urandom_range(0, 1)) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return t_coord'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic set_curve(t_coord fz, t_coord lz, t_coord ax, t_coord ay,
                             t_coord bx, t_coord by);
        write_reg(CFG_FIRST_Z, fz);
        write_reg(CFG_LAST_Z, lz);
        write_reg(CFG_P2_X, ax);
        write_reg(CFG_P2_Y, ay);
        write_reg(CFG_P3_X, bx);
        write_reg(CFG_P3_Y, by);
    endtask

    task automatic random_phase(int count);
        int burst;
        int zmode;
        for (int i = 0; i < count; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && i < count; b++, i++) begin
                zmode = $urandom_range(0, 9);
                if (zmode < 6)
                    send_vertex(rand_coord($urandom_range(0, 3)),
                                rand_coord($urandom_range(0, 3)),
                                rand_coord(1));
                else
                    send_vertex(rand_coord($urandom_range(0, 3)),
                                rand_coord($urandom_range(0, 3)),
                                rand_coord($urandom_range(0, 2)));
            end
            if ($urandom_range(0, 3) != 0) pause_sender;
        end
    endtask

    t_coord fz, lz;

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset curve: t = z, control points zero
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh00008000);
        send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        in_valid <= 1'b0;
        drain;

        // directed: equal ends
        set_curve(32'sh00010000, 32'sh00010000, 32'sh7FFFFFFF, 32'sh80000000,
                  32'sh12345678, 32'shFEDCBA98);
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        send_vertex(32'sh00000001, 32'shFFFFFFFF, 32'sh00010000);
        in_valid <= 1'b0;
        drain;

        // directed: extreme control points, far vertices, span extremes
        set_curve(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                  32'sh80000000, 32'sh7FFFFFFF);
        send_vertex(32'sh00000000, 32'sh00000000, 32'sh80000000);
        send_vertex(32'sh00000000, 32'sh00000000, 32'sh00000000);
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh40000000);
        send_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        in_valid <= 1'b0;
        drain;
        set_curve(32'sh00000000, 32'sh00000001, 32'sh00100000, 32'shFFF00000,
                  32'shFFF00000, 32'sh00100000);
        send_vertex(32'sh00000000, 32'sh00000000, 32'sh7FFFFFFF);
        send_vertex(32'sh00000000, 32'sh00000000, 32'sh80000000);
        send_vertex(32'sh00000005, 32'shFFFFFFFB, 32'sh00000001);
        send_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh00000003);
        in_valid <= 1'b0;
        drain;
        set_curve(32'sh00050000, 32'shFFFB0000, 32'sh00020000, 32'sh00030000,
                  32'shFFFD0000, 32'sh00010000);
        send_vertex(32'sh00001000, 32'sh00002000, 32'sh00000000);
        send_vertex(32'sh00001000, 32'sh00002000, 32'shFFFB0000);
        send_vertex(32'sh00001000, 32'sh00002000, 32'sh00080000);
        // unknown register index must be ignored
        in_valid <= 1'b0;
        drain;
        write_reg(t_cfg_idx'(6), 32'sh00000000);
        write_reg(t_cfg_idx'(7), 32'sh00000000);
        send_vertex(32'sh00000000, 32'sh00000000, 32'sh00020000);
        in_valid <= 1'b0;
        drain;

        // random phases with changing curves and receiver behavior
        for (int ph = 0; ph < 16; ph++) begin
            stall_mode = ph % 4;
            case (ph % 5)
                0: begin
                    fz = rand_coord(3);
                    lz = fz;
                end
                1: begin
                    fz = rand_coord(0);
                    lz = rand_coord(0);
                end
                2: begin
                    fz = rand_coord(2);
                    lz = rand_coord(2);
                end
                default: begin
                    fz = rand_coord(1);
                    lz = fz + t_coord'($signed($urandom_range(1, 8 * 65536)))
                        * (($urandom_range(0, 1)) ? 1 : -1);
                end
            endcase
            set_curve(fz, lz, rand_coord($urandom_range(0, 3)),
                      rand_coord($urandom_range(0, 3)),
                      rand_coord($urandom_range(0, 3)),
                      rand_coord($urandom_range(0, 3)));
            random_phase(100);
            in_valid <= 1'b0;
            drain;
        end

        // final stretch with no idling on either side
        stall_mode = 0;
        set_curve(32'sh00000000, 32'sh00100000, 32'sh00080000, 32'shFFF80000,
                  32'sh00040000, 32'sh00020000);
        for (int i = 0; i < 40; i++)
            send_vertex(rand_coord(0), rand_coord(0), rand_coord(1));
        in_valid <= 1'b0;
        drain;

        $display("%0d vertices sent, %0d checked; %0d degenerate, %0d saturated x",
                 sent, results, degen_seen, sat_seen);
        $display("covered 21 curve settings incl. extremes and stalls");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
